// ===== rtl/core/hbed_pkg.sv =====
// shared types and constants of the huffman codec
// no dependencies
package hbed_pkg;

  localparam int unsigned SymCnt     = 256;
  localparam int unsigned SymW       = 8;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned NodeWW     = WeightBits + SymW;
  localparam int unsigned NodeDepth  = 2 * SymCnt - 1;
  localparam int unsigned NidxW      = 9;
  localparam int unsigned MaxCode    = 34;
  localparam int unsigned ClenW      = 6;
  localparam int unsigned InW        = 32;
  localparam int unsigned OutW       = 56;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_BUILD  = 3'd1,
    ACT_ENCODE = 3'd2,
    ACT_DECODE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_SYM  = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_NOTREE  = 3'd3,
    ST_ONELEAF = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_LEAF_RD,
    FS_LEAF_WR,
    FS_LEAF_END,
    FS_SCAN,
    FS_MERGE,
    FS_ROOT,
    FS_CODE_RD,
    FS_CODE_EV,
    FS_CODE_R,
    FS_FINISH,
    FS_ENC,
    FS_DEC_A,
    FS_DEC_B
  } fsm_e;

  typedef struct packed {
    logic [NodeWW-1:0] weight;
    logic [NidxW-1:0]  left;
    logic [NidxW-1:0]  right;
    logic [SymW-1:0]   sym;
    logic              leaf;
  } node_t;

  typedef struct packed {
    logic [ClenW-1:0]   len;
    logic [MaxCode-1:0] bits;
  } path_t;

endpackage

// ===== rtl/core/huffman_build_encode_decode.sv =====
// huffman codec: weight store, tree builder, code table, encoder, bit-serial decoder
// depends on hbed_pkg
// load, clear and error answers come from idle; encode reads the code table and a
// decode bit reads two nodes; build reads each symbol slot, then per merge scans all
//   nodes so far, then visits every node for the code pass over one node memory port
// one item at a time: the input is not ready until the result has been transferred
// reset clears weight presence, tree status and walk; memories hold no reset value
module huffman_build_encode_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // action[2:0], symbol[10:3], weight[26:11], code_bit[27], zero pad
  input  logic [hbed_pkg::InW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // status[2:0], symbol_valid[3], out_symbol[11:4], code_length[17:12],
  // code_value[51:18], zero pad
  output logic [hbed_pkg::OutW-1:0] m_axis_tdata_o
);
  import hbed_pkg::*;

  // input fields
  logic [2:0]            in_act;
  logic [SymW-1:0]       in_sym;
  logic [WeightBits-1:0] in_w;
  logic                  in_bit;
  logic                  in_fire;
  assign in_act = s_axis_tdata_i[2:0];
  assign in_sym = s_axis_tdata_i[10:3];
  assign in_w   = s_axis_tdata_i[26:11];
  assign in_bit = s_axis_tdata_i[27];

  // memories
  logic [WeightBits-1:0] wmem [SymCnt];
  node_t                 node_mem [NodeDepth];
  path_t                 path_mem [NodeDepth];
  path_t                 code_mem [SymCnt];

  logic                  wm_we, wm_re;
  logic [SymW-1:0]       wm_wa, wm_ra;
  logic [WeightBits-1:0] wm_rd_q;
  logic                  nd_we, nd_re;
  logic [NidxW-1:0]      nd_wa, nd_ra;
  node_t                 nd_wd, nd_rd_q;
  logic                  pm_we, pm_re;
  logic [NidxW-1:0]      pm_wa, pm_ra;
  path_t                 pm_wd, pm_rd_q;
  logic                  cm_we, cm_re;
  logic [SymW-1:0]       cm_wa, cm_ra;
  path_t                 cm_wd, cm_rd_q;

  always_ff @(posedge clk_i) begin
    if (wm_we) wmem[wm_wa] <= in_w;
    if (wm_re) wm_rd_q <= wmem[wm_ra];
    if (nd_we) node_mem[nd_wa] <= nd_wd;
    if (nd_re) nd_rd_q <= node_mem[nd_ra];
    if (pm_we) path_mem[pm_wa] <= pm_wd;
    if (pm_re) pm_rd_q <= path_mem[pm_ra];
    if (cm_we) code_mem[cm_wa] <= cm_wd;
    if (cm_re) cm_rd_q <= code_mem[cm_ra];
  end

  // control state
  fsm_e                 state_q, state_d;
  logic [SymCnt-1:0]    wvalid_q, wvalid_d;
  logic [SymCnt-1:0]    cvalid_q, cvalid_d;
  logic [NodeDepth-1:0] alive_q, alive_d;
  logic                 ready_q, ready_d;
  logic [NidxW-1:0]     walk_q, walk_d;
  logic [NidxW-1:0]     root_q, root_d;
  logic [NidxW-1:0]     leaves_q, leaves_d;
  logic [NidxW-1:0]     slot_q, slot_d;
  logic [NidxW-1:0]     n_q, n_d;
  logic [NidxW-1:0]     total_q, total_d;
  logic [NidxW-1:0]     j_q, j_d;
  logic [NidxW-1:0]     i_q, i_d;
  logic                 pend_q, pend_d;
  logic [NidxW-1:0]     pidx_q, pidx_d;
  logic                 bok_q, bok_d, sok_q, sok_d;
  logic [NidxW-1:0]     bidx_q, bidx_d, sidx_q, sidx_d;
  logic [NodeWW-1:0]    bw_q, bw_d, sw_q, sw_d;
  logic [NidxW-1:0]     nxt_q, nxt_d;
  logic [SymW-1:0]      sym_q, sym_d;
  logic                 bit_q, bit_d;

  logic               out_valid_q;
  logic               out_ld;
  logic [2:0]         o_status_d, o_status_q;
  logic               o_sv_d, o_sv_q;
  logic [SymW-1:0]    o_sym_d, o_sym_q;
  logic [ClenW-1:0]   o_len_d, o_len_q;
  logic [MaxCode-1:0] o_val_d, o_val_q;

  logic [NidxW-1:0] last_total;
  assign last_total = NidxW'({1'b0, n_q, 1'b0} - (NidxW + 1)'(1));

  assign s_axis_tready_o = (state_q == FS_IDLE) && !out_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  function automatic path_t extend(path_t p, logic c);
    path_t r;
    r = p;
    if (p.len < ClenW'(MaxCode)) begin
      r.bits = {p.bits[MaxCode-2:0], c};
      r.len  = p.len + ClenW'(1);
    end
    return r;
  endfunction

  always_comb begin
    state_d  = state_q;
    wvalid_d = wvalid_q;
    cvalid_d = cvalid_q;
    alive_d  = alive_q;
    ready_d  = ready_q;
    walk_d   = walk_q;
    root_d   = root_q;
    leaves_d = leaves_q;
    slot_d   = slot_q;
    n_d      = n_q;
    total_d  = total_q;
    j_d      = j_q;
    i_d      = i_q;
    pend_d   = 1'b0;
    pidx_d   = j_q;
    bok_d    = bok_q;
    sok_d    = sok_q;
    bidx_d   = bidx_q;
    sidx_d   = sidx_q;
    bw_d     = bw_q;
    sw_d     = sw_q;
    nxt_d    = nxt_q;
    sym_d    = sym_q;
    bit_d    = bit_q;
    wm_we = 1'b0; wm_wa = in_sym; wm_re = 1'b0; wm_ra = slot_q[SymW-1:0];
    nd_we = 1'b0; nd_wa = n_q; nd_wd = '0; nd_re = 1'b0; nd_ra = j_q;
    pm_we = 1'b0; pm_wa = root_q; pm_wd = '0; pm_re = 1'b0; pm_ra = i_q;
    cm_we = 1'b0; cm_wa = nd_rd_q.sym; cm_wd = pm_rd_q; cm_re = 1'b0; cm_ra = in_sym;
    out_ld     = 1'b0;
    o_status_d = ST_OK;
    o_sv_d     = 1'b0;
    o_sym_d    = '0;
    o_len_d    = '0;
    o_val_d    = '0;

    unique case (state_q)
      FS_IDLE: begin
        if (in_fire) begin
          sym_d = in_sym;
          bit_d = in_bit;
          priority case (in_act)
            ACT_LOAD: begin
              wm_we = 1'b1;
              wvalid_d[in_sym] = 1'b1;
              out_ld = 1'b1;
            end
            ACT_BUILD: begin
              cvalid_d = '0;
              alive_d  = '0;
              slot_d   = '0;
              n_d      = '0;
              state_d  = FS_LEAF_RD;
            end
            ACT_ENCODE: begin
              if (!ready_q) begin
                o_status_d = ST_NOTREE;
                out_ld = 1'b1;
              end else begin
                cm_re = 1'b1;
                state_d = FS_ENC;
              end
            end
            ACT_DECODE: begin
              if (!ready_q) begin
                o_status_d = ST_NOTREE;
                out_ld = 1'b1;
              end else if (leaves_q < NidxW'(2)) begin
                o_status_d = ST_ONELEAF;
                out_ld = 1'b1;
              end else begin
                nd_re = 1'b1;
                nd_ra = walk_q;
                state_d = FS_DEC_A;
              end
            end
            ACT_CLEAR: begin
              wvalid_d = '0;
              out_ld = 1'b1;
            end
            default: out_ld = 1'b1;
          endcase
        end
      end
      FS_LEAF_RD: begin
        wm_re = 1'b1;
        state_d = FS_LEAF_WR;
      end
      FS_LEAF_WR: begin
        if (wvalid_q[slot_q[SymW-1:0]]) begin
          nd_we = 1'b1;
          nd_wa = n_q;
          nd_wd.weight = NodeWW'(wm_rd_q);
          nd_wd.sym    = slot_q[SymW-1:0];
          nd_wd.leaf   = 1'b1;
          alive_d[n_q] = 1'b1;
          n_d = n_q + NidxW'(1);
        end
        slot_d = slot_q + NidxW'(1);
        state_d = (slot_q == NidxW'(SymCnt - 1)) ? FS_LEAF_END : FS_LEAF_RD;
      end
      FS_LEAF_END: begin
        total_d = n_q;
        j_d = '0;
        bok_d = 1'b0;
        sok_d = 1'b0;
        if (n_q == '0) state_d = FS_FINISH;
        else if (n_q == NidxW'(1)) state_d = FS_ROOT;
        else state_d = FS_SCAN;
      end
      FS_SCAN: begin
        // one node read per cycle, compare against the two lowest so far
        if (j_q != total_q) begin
          nd_re = 1'b1;
          nd_ra = j_q;
          pend_d = 1'b1;
          pidx_d = j_q;
          j_d = j_q + NidxW'(1);
        end
        if (pend_q && alive_q[pidx_q]) begin
          if (!bok_q || nd_rd_q.weight < bw_q) begin
            sok_d = bok_q; sidx_d = bidx_q; sw_d = bw_q;
            bok_d = 1'b1;  bidx_d = pidx_q; bw_d = nd_rd_q.weight;
          end else if (!sok_q || nd_rd_q.weight < sw_q) begin
            sok_d = 1'b1; sidx_d = pidx_q; sw_d = nd_rd_q.weight;
          end
        end
        if (j_q == total_q && !pend_q) state_d = FS_MERGE;
      end
      FS_MERGE: begin
        nd_we = 1'b1;
        nd_wa = total_q;
        nd_wd.weight = bw_q + sw_q;
        nd_wd.left   = bidx_q;
        nd_wd.right  = sidx_q;
        alive_d[bidx_q]  = 1'b0;
        alive_d[sidx_q]  = 1'b0;
        alive_d[total_q] = 1'b1;
        total_d = total_q + NidxW'(1);
        j_d = '0;
        bok_d = 1'b0;
        sok_d = 1'b0;
        state_d = (total_d == last_total) ? FS_ROOT : FS_SCAN;
      end
      FS_ROOT: begin
        root_d = total_q - NidxW'(1);
        i_d = total_q - NidxW'(1);
        pm_we = 1'b1;
        pm_wa = total_q - NidxW'(1);
        state_d = FS_CODE_RD;
      end
      FS_CODE_RD: begin
        nd_re = 1'b1;
        nd_ra = i_q;
        pm_re = 1'b1;
        state_d = FS_CODE_EV;
      end
      FS_CODE_EV: begin
        if (nd_rd_q.leaf) begin
          cm_we = 1'b1;
          cvalid_d[nd_rd_q.sym] = 1'b1;
          i_d = i_q - NidxW'(1);
          state_d = (i_q == '0) ? FS_FINISH : FS_CODE_RD;
        end else begin
          pm_we = 1'b1;
          pm_wa = nd_rd_q.left;
          pm_wd = extend(pm_rd_q, 1'b0);
          state_d = FS_CODE_R;
        end
      end
      FS_CODE_R: begin
        pm_we = 1'b1;
        pm_wa = nd_rd_q.right;
        pm_wd = extend(pm_rd_q, 1'b1);
        i_d = i_q - NidxW'(1);
        state_d = (i_q == '0) ? FS_FINISH : FS_CODE_RD;
      end
      FS_FINISH: begin
        out_ld = 1'b1;
        leaves_d = n_q;
        if (n_q == '0) begin
          ready_d = 1'b0;
          o_status_d = ST_NO_SYM;
        end else begin
          ready_d = 1'b1;
          walk_d = root_q;
        end
        state_d = FS_IDLE;
      end
      FS_ENC: begin
        out_ld = 1'b1;
        if (!cvalid_q[sym_q]) begin
          o_status_d = ST_ABSENT;
        end else begin
          o_len_d = cm_rd_q.len;
          o_val_d = cm_rd_q.bits;
        end
        state_d = FS_IDLE;
      end
      FS_DEC_A: begin
        nxt_d = bit_q ? nd_rd_q.right : nd_rd_q.left;
        nd_re = 1'b1;
        nd_ra = bit_q ? nd_rd_q.right : nd_rd_q.left;
        state_d = FS_DEC_B;
      end
      FS_DEC_B: begin
        out_ld = 1'b1;
        if (nd_rd_q.leaf) begin
          o_sv_d = 1'b1;
          o_sym_d = nd_rd_q.sym;
          walk_d = root_q;
        end else begin
          walk_d = nxt_q;
        end
        state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      wvalid_q    <= '0;
      cvalid_q    <= '0;
      alive_q     <= '0;
      ready_q     <= 1'b0;
      walk_q      <= '0;
      root_q      <= '0;
      leaves_q    <= '0;
      slot_q      <= '0;
      n_q         <= '0;
      total_q     <= '0;
      j_q         <= '0;
      i_q         <= '0;
      pend_q      <= 1'b0;
      bok_q       <= 1'b0;
      sok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wvalid_q <= wvalid_d;
      cvalid_q <= cvalid_d;
      alive_q  <= alive_d;
      ready_q  <= ready_d;
      walk_q   <= walk_d;
      root_q   <= root_d;
      leaves_q <= leaves_d;
      slot_q   <= slot_d;
      n_q      <= n_d;
      total_q  <= total_d;
      j_q      <= j_d;
      i_q      <= i_d;
      pend_q   <= pend_d;
      bok_q    <= bok_d;
      sok_q    <= sok_d;
      if (out_ld) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    bidx_q <= bidx_d;
    sidx_q <= sidx_d;
    bw_q   <= bw_d;
    sw_q   <= sw_d;
    nxt_q  <= nxt_d;
    sym_q  <= sym_d;
    bit_q  <= bit_d;
    if (out_ld) begin
      o_status_q <= o_status_d;
      o_sv_q     <= o_sv_d;
      o_sym_q    <= o_sym_d;
      o_len_q    <= o_len_d;
      o_val_q    <= o_val_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, o_val_q, o_len_q, o_sym_q, o_sv_q, o_status_q};

  // a result is only produced while no other is waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !out_ld)
    else $error("result overwritten before transfer");

  // merge always has two live nodes to join
  a_merge_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FS_MERGE |-> bok_q && sok_q && bidx_q != sidx_q)
    else $error("merge without two distinct nodes");

  // a decoded symbol comes with ok status and leaves the walk at the root
  a_dec_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld && o_sv_d |=> walk_q == root_q && o_status_q == ST_OK)
    else $error("walk not reset after leaf");

  // the code pass never stores a code longer than the saturated length
  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_we |-> pm_wd.len <= ClenW'(MaxCode))
    else $error("code length beyond limit");

endmodule
